// File: rtl/drsd_pkg.sv
// Package for the descending depth sort: item layout and fixed widths.
`default_nettype none
package drsd_pkg;
    localparam int KEY_W = 32;
    localparam int TAG_W = 16;
    localparam int ITEM_W = KEY_W + TAG_W;

    typedef struct packed {
        logic [TAG_W-1:0] tag;
        logic [KEY_W-1:0] key;
    } item_t;
endpackage
`default_nettype wire

// File: rtl/drsd_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
`default_nettype none
module drsd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// File: rtl/depth_radix_sort_descending.sv
// Top level of the descending depth sort (LSD radix sort, farthest item first).
// Items are loaded one per cycle while ready is high; up to MAX_ITEMS items are
// kept and later ones in the batch are dropped and flagged. The final item starts
// a stable radix sort with DIGIT_BITS-bit digits, ceil(32/DIGIT_BITS) passes. Each
// pass clears 2^DIGIT_BITS bucket counters one a cycle, histograms n items (plus
// one extra visit that flushes the last increment), forms the prefix over the
// buckets and scatters n items; the ping-pong item store then swaps. The pace of
// the sort is set by the single bucket RAM port and the registered reads of both
// RAMs. Results then leave through an output register, in reverse order of the
// sorted store. Ready returns once the last result of the batch sits in the output
// register, so the next batch may load while that word waits.
`default_nettype none
module depth_radix_sort_descending
    import drsd_pkg::*;
#(
    parameter int MAX_ITEMS = 64,
    parameter int DIGIT_BITS = 8
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire logic [KEY_W-1:0] s_distance_bits,
    input  wire logic [TAG_W-1:0] s_face_tag,
    input  wire logic             s_is_final,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output logic      [TAG_W-1:0] m_sorted_tag,
    output logic      [KEY_W-1:0] m_sorted_key,
    output logic                  m_end_of_run,
    output logic                  m_overflowed
);
    localparam int AW = $clog2(MAX_ITEMS);
    localparam int CW = $clog2(MAX_ITEMS + 1);
    localparam int BUCKETS = 1 << DIGIT_BITS;
    localparam int NUM_PASSES = (KEY_W + DIGIT_BITS - 1) / DIGIT_BITS;
    localparam int PW = (NUM_PASSES > 1) ? $clog2(NUM_PASSES) : 1;
    localparam int SW = $clog2(KEY_W);

    typedef enum logic [3:0] {
        S_LOAD, S_CLR, S_HRD, S_HUPD, S_PFX_RD, S_PFX_WR,
        S_SRD, S_SBK, S_SWR, S_ERD, S_EOUT
    } state_t;

    state_t state_reg;
    logic [CW-1:0] count_reg;
    logic drop_reg;
    logic bank_reg;
    logic [PW-1:0] pass_reg;
    logic [CW-1:0] idx_reg;
    logic [DIGIT_BITS:0] bidx_reg;
    logic [CW-1:0] run_reg;
    logic [DIGIT_BITS-1:0] digit_reg;
    item_t item_reg;

    // Item banks: bank_reg selects the bank that holds the current order.
    logic we0, we1;
    logic [AW-1:0] wa0, wa1, ra;
    item_t wd, rd0, rd1, rd;
    logic b_we;
    logic [DIGIT_BITS-1:0] b_wa, b_ra;
    logic [CW-1:0] b_wd, b_rd;

    drsd_ram #(.WIDTH(ITEM_W), .DEPTH(MAX_ITEMS)) u_bank0 (
        .aclk(aclk), .we(we0), .waddr(wa0), .wdata(wd), .raddr(ra), .rdata(rd0));
    drsd_ram #(.WIDTH(ITEM_W), .DEPTH(MAX_ITEMS)) u_bank1 (
        .aclk(aclk), .we(we1), .waddr(wa1), .wdata(wd), .raddr(ra), .rdata(rd1));
    drsd_ram #(.WIDTH(CW), .DEPTH(BUCKETS)) u_buckets (
        .aclk(aclk), .we(b_we), .waddr(b_wa), .wdata(b_wd), .raddr(b_ra),
        .rdata(b_rd));

    assign rd = bank_reg ? rd1 : rd0;

    logic [SW+PW:0] shift_amt;
    logic [KEY_W-1:0] shifted;
    logic [DIGIT_BITS-1:0] rd_digit;
    assign shift_amt = (SW + PW + 1)'(pass_reg) * (SW + PW + 1)'(DIGIT_BITS);
    assign shifted = rd.key >> shift_amt;
    assign rd_digit = shifted[DIGIT_BITS-1:0];

    logic accept_in;
    assign s_ready = (state_reg == S_LOAD);
    assign accept_in = s_valid && s_ready;

    always_comb begin
        we0 = 1'b0;
        we1 = 1'b0;
        wa0 = idx_reg[AW-1:0];
        wa1 = b_rd[AW-1:0];
        wd = item_reg;
        ra = idx_reg[AW-1:0];
        b_we = 1'b0;
        b_wa = bidx_reg[DIGIT_BITS-1:0];
        b_wd = '0;
        b_ra = bidx_reg[DIGIT_BITS-1:0];
        unique case (state_reg)
            S_LOAD: begin
                wa0 = count_reg[AW-1:0];
                wd.key = s_distance_bits;
                wd.tag = s_face_tag;
                we0 = accept_in && (count_reg < CW'(MAX_ITEMS)) && !bank_reg;
                wa1 = count_reg[AW-1:0];
                we1 = accept_in && (count_reg < CW'(MAX_ITEMS)) && bank_reg;
            end
            S_CLR: begin
                b_we = 1'b1;
            end
            S_HRD: begin
                b_ra = rd_digit;
            end
            S_HUPD: begin
                b_ra = digit_reg;
                b_wa = digit_reg;
                b_wd = b_rd + CW'(1);
                b_we = (idx_reg != '0);
            end
            S_PFX_WR: begin
                b_wa = bidx_reg[DIGIT_BITS-1:0];
                b_wd = run_reg;
                b_we = 1'b1;
            end
            S_SBK: begin
                b_ra = rd_digit;
            end
            S_SWR: begin
                b_wa = digit_reg;
                b_wd = b_rd + CW'(1);
                b_we = 1'b1;
                wa0 = b_rd[AW-1:0];
                wa1 = b_rd[AW-1:0];
                we0 = bank_reg;
                we1 = !bank_reg;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_LOAD;
            count_reg <= '0;
            drop_reg <= 1'b0;
            bank_reg <= 1'b0;
            m_valid <= 1'b0;
            pass_reg <= '0;
            idx_reg <= '0;
            bidx_reg <= '0;
            run_reg <= '0;
        end else begin
            unique case (state_reg)
                S_LOAD: begin
                    if (accept_in) begin
                        if (count_reg < CW'(MAX_ITEMS)) begin
                            count_reg <= count_reg + CW'(1);
                        end else begin
                            drop_reg <= 1'b1;
                        end
                        if (s_is_final) begin
                            pass_reg <= '0;
                            bidx_reg <= '0;
                            state_reg <= S_CLR;
                        end
                    end
                end
                S_CLR: begin
                    bidx_reg <= bidx_reg + (DIGIT_BITS + 1)'(1);
                    if (bidx_reg == (DIGIT_BITS + 1)'(BUCKETS - 1)) begin
                        idx_reg <= '0;
                        state_reg <= S_HUPD;
                    end
                end
                // Histogram: read item, then read its counter; the increment lands
                // on the next visit. A final visit with idx==count flushes it.
                S_HUPD: begin
                    state_reg <= S_HRD;
                end
                S_HRD: begin
                    digit_reg <= rd_digit;
                    if (idx_reg == count_reg) begin
                        bidx_reg <= '0;
                        run_reg <= '0;
                        state_reg <= S_PFX_RD;
                    end else begin
                        idx_reg <= idx_reg + CW'(1);
                        state_reg <= S_HUPD;
                    end
                end
                S_PFX_RD: begin
                    state_reg <= S_PFX_WR;
                end
                S_PFX_WR: begin
                    run_reg <= run_reg + b_rd;
                    if (bidx_reg == (DIGIT_BITS + 1)'(BUCKETS - 1)) begin
                        idx_reg <= '0;
                        state_reg <= S_SRD;
                    end else begin
                        bidx_reg <= bidx_reg + (DIGIT_BITS + 1)'(1);
                        state_reg <= S_PFX_RD;
                    end
                end
                S_SRD: begin
                    state_reg <= S_SBK;
                end
                S_SBK: begin
                    digit_reg <= rd_digit;
                    item_reg <= rd;
                    state_reg <= S_SWR;
                end
                S_SWR: begin
                    if (idx_reg + CW'(1) == count_reg) begin
                        bank_reg <= !bank_reg;
                        bidx_reg <= '0;
                        if (pass_reg == PW'(NUM_PASSES - 1)) begin
                            idx_reg <= count_reg - CW'(1);
                            state_reg <= S_ERD;
                        end else begin
                            pass_reg <= pass_reg + PW'(1);
                            state_reg <= S_CLR;
                        end
                    end else begin
                        idx_reg <= idx_reg + CW'(1);
                        state_reg <= S_SRD;
                    end
                end
                S_ERD: begin
                    if (!m_valid || m_ready) begin
                        state_reg <= S_EOUT;
                    end
                end
                S_EOUT: begin
                    m_valid <= 1'b1;
                    m_sorted_tag <= rd.tag;
                    m_sorted_key <= rd.key;
                    m_overflowed <= drop_reg;
                    m_end_of_run <= (idx_reg == '0);
                    if (idx_reg == '0) begin
                        count_reg <= '0;
                        drop_reg <= 1'b0;
                        state_reg <= S_LOAD;
                    end else begin
                        idx_reg <= idx_reg - CW'(1);
                        state_reg <= S_ERD;
                    end
                end
                default: begin
                    state_reg <= S_LOAD;
                end
            endcase
            // Retire a word once taken, whatever the sequencer is doing.
            if (m_valid && m_ready) begin
                m_valid <= 1'b0;
            end
        end
    end
endmodule
`default_nettype wire

// File: tb/tb.sv
// Testbench for the descending depth sort: directed and random batches checked against an in-bench sorter.
`timescale 1ns / 1ps
`default_nettype none
module tb;
    import drsd_pkg::*;

    localparam int CAPACITY = 64;
    localparam int STALL_LIMIT = 20000;

    typedef struct {
        logic [KEY_W-1:0] key;
        logic [TAG_W-1:0] tag;
        logic             last;
    } load_word_t;

    typedef struct {
        logic [TAG_W-1:0] tag;
        logic [KEY_W-1:0] key;
        logic             eor;
        logic             ovf;
    } sorted_word_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [KEY_W-1:0] s_distance_bits = '0;
    logic [TAG_W-1:0] s_face_tag = '0;
    logic s_is_final = 1'b0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [TAG_W-1:0] m_sorted_tag;
    logic [KEY_W-1:0] m_sorted_key;
    logic m_end_of_run;
    logic m_overflowed;

    depth_radix_sort_descending DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_distance_bits(s_distance_bits), .s_face_tag(s_face_tag),
        .s_is_final(s_is_final),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_sorted_tag(m_sorted_tag), .m_sorted_key(m_sorted_key),
        .m_end_of_run(m_end_of_run), .m_overflowed(m_overflowed)
    );

    load_word_t   pending_loads[$];
    sorted_word_t expected_order[$];
    logic [KEY_W-1:0] batch_keys[$];
    logic [TAG_W-1:0] batch_tags[$];
    logic batch_dropped = 1'b0;

    int mismatches = 0;
    int results_seen = 0;
    int batches_seen = 0;
    int idle_cycles = 0;
    int cycle_count = 0;
    bit timed_out = 1'b0;
    bit pause_req = 1'b0;
    bit stimulus_done = 1'b0;
    bit sent_final = 1'b1;

    // Stable ascending sort on unsigned keys, then emit reversed.
    task automatic sort_batch_into_expected();
        int n;
        logic [KEY_W-1:0] k;
        logic [TAG_W-1:0] t;
        int j;
        sorted_word_t w;
        n = batch_keys.size();
        for (int i = 1; i < n; i++) begin
            k = batch_keys[i];
            t = batch_tags[i];
            j = i - 1;
            while (j >= 0 && batch_keys[j] > k) begin
                batch_keys[j+1] = batch_keys[j];
                batch_tags[j+1] = batch_tags[j];
                j--;
            end
            batch_keys[j+1] = k;
            batch_tags[j+1] = t;
        end
        for (int i = n - 1; i >= 0; i--) begin
            w.tag = batch_tags[i];
            w.key = batch_keys[i];
            w.eor = (i == 0);
            w.ovf = batch_dropped;
            expected_order.insert(expected_order.size(), w);
        end
        batch_keys.delete();
        batch_tags.delete();
        batch_dropped = 1'b0;
    endtask

    function automatic logic [KEY_W-1:0] rand_key();
        case ($urandom_range(0, 5))
            0: rand_key = $urandom_range(0, 7);
            1: rand_key = 32'hFFFF_FFF0 | $urandom_range(0, 15);
            2: rand_key = {2'($urandom_range(0, 3)), 30'h0} | $urandom_range(0, 3);
            default: rand_key = $urandom;
        endcase
    endfunction

    task automatic add_batch(int n, bit dup_keys);
        load_word_t w;
        logic [KEY_W-1:0] base;
        base = rand_key();
        for (int i = 0; i < n; i++) begin
            w.key = dup_keys ? (base ^ $urandom_range(0, 1)) : rand_key();
            w.tag = 16'($urandom);
            w.last = (i == n - 1);
            pending_loads.insert(pending_loads.size(), w);
        end
    endtask

    initial begin
        forever #5 aclk = ~aclk;
    end

    initial begin
        load_word_t w;
        int total;
        // Directed: single item, extremes, equal keys, sign bit, overflow.
        w.key = 32'h0; w.tag = 16'h0; w.last = 1'b1;
        pending_loads.insert(pending_loads.size(), w);
        w.key = 32'hFFFF_FFFF; w.tag = 16'hFFFF; w.last = 1'b0;
        pending_loads.insert(pending_loads.size(), w);
        w.key = 32'h8000_0000; w.tag = 16'h1234;
        pending_loads.insert(pending_loads.size(), w);
        w.key = 32'h7F80_0000; w.tag = 16'hAAAA;
        pending_loads.insert(pending_loads.size(), w);
        w.key = 32'h7FC0_0001; w.tag = 16'h5555;
        pending_loads.insert(pending_loads.size(), w);
        w.key = 32'h3F80_0000; w.tag = 16'h0001;
        pending_loads.insert(pending_loads.size(), w);
        w.key = 32'h3F80_0000; w.tag = 16'h0002;
        pending_loads.insert(pending_loads.size(), w);
        w.key = 32'h0000_0001; w.tag = 16'h8000; w.last = 1'b1;
        pending_loads.insert(pending_loads.size(), w);
        add_batch(2, 1'b1);
        // Overflow: capacity plus extra, final item dropped.
        add_batch(CAPACITY + 3, 1'b0);
        total = pending_loads.size();
        while (total < 330) begin
            int n;
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 70) : $urandom_range(1, 12);
            add_batch(n, $urandom_range(0, 3) == 0);
            total += n;
        end
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        wait (pending_loads.size() < 200);
        // Finish the open batch, then hold off until every expected word has drained.
        pause_req = 1'b1;
        wait (sent_final && !s_valid && expected_order.size() == 0 &&
              batch_keys.size() == 0);
        repeat (5) @(posedge aclk);
        pause_req = 1'b0;
        wait (pending_loads.size() == 0 && !s_valid);
        stimulus_done = 1'b1;
    end

    // Driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                if (s_is_final) begin
                    batches_seen++;
                end
            end
            if (!s_valid || s_ready) begin
                if (pending_loads.size() > 0 && !(pause_req && sent_final) &&
                    (cycle_count % 2000 < 400 || $urandom_range(0, 99) >= 28)) begin
                    load_word_t w;
                    w = pending_loads.pop_front();
                    sent_final = w.last;
                    s_valid <= 1'b1;
                    s_distance_bits <= w.key;
                    s_face_tag <= w.tag;
                    s_is_final <= w.last;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Track accepted words for prediction.
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) begin
            if (batch_keys.size() < CAPACITY) begin
                batch_keys.insert(batch_keys.size(), s_distance_bits);
                batch_tags.insert(batch_tags.size(), s_face_tag);
            end else begin
                batch_dropped = 1'b1;
            end
            if (s_is_final) begin
                sort_batch_into_expected();
            end
        end
    end

    // Monitor
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= (cycle_count % 2000 < 400) || ($urandom_range(0, 99) >= 28);
            if (m_valid && m_ready) begin
                results_seen++;
                if (expected_order.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("unexpected word: tag=%h key=%h", m_sorted_tag, m_sorted_key);
                    end
                end else begin
                    sorted_word_t e;
                    e = expected_order.pop_front();
                    if (e.tag !== m_sorted_tag || e.key !== m_sorted_key ||
                        e.eor !== m_end_of_run || e.ovf !== m_overflowed) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("mismatch: exp %h %h %b %b, got %h %h %b %b",
                                     e.tag, e.key, e.eor, e.ovf,
                                     m_sorted_tag, m_sorted_key, m_end_of_run, m_overflowed);
                        end
                    end
                end
            end
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            timed_out = 1'b1;
        end
    end

    initial begin
        wait (timed_out || (stimulus_done && expected_order.size() == 0));
        if (!timed_out) begin
            repeat (50) @(posedge aclk);
        end
        $display("Covered %0d batches, %0d sorted words checked, incl. overflow and ties.",
                 batches_seen, results_seen);
        if (!timed_out && mismatches == 0 && expected_order.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule
`default_nettype wire
